// ----- rtl/bsp_pkg.sv -----
// Shared constants, codes and state encoding for the back-projection stack peak block.
// Used by backprojection_stack_peak and bsp_checker; depends on nothing else.
`default_nettype none

package bsp_pkg;

  // Store geometry.
  localparam int MAX_STATIONS  = 64;
  localparam int TRACE_SAMPLES = 4096;
  localparam int NUM_WINDOWS   = 32;
  localparam int TABLE_ROWS    = 64;
  localparam int TABLE_COLS    = 256;

  localparam int ST_BITS   = $clog2(MAX_STATIONS);
  localparam int SMP_BITS  = $clog2(TRACE_SAMPLES);
  localparam int ROW_BITS  = $clog2(TABLE_ROWS);
  localparam int COL_BITS  = $clog2(TABLE_COLS);
  localparam int WIN_LEN   = TRACE_SAMPLES / NUM_WINDOWS;
  localparam int WIN_BITS  = $clog2(WIN_LEN);
  localparam int WIDX_BITS = 5;

  // Iterative unit lengths and the stack word width (64 x 16-bit signed sum).
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 53;
  localparam int ACC_W      = 23;

  typedef enum logic [1:0] {
    CMD_POS    = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_TIME   = 2'd2,
    CMD_EVAL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_GX_ORIGIN  = 3'd0,
    REG_GY_ORIGIN  = 3'd1,
    REG_GX_SPACING = 3'd2,
    REG_GY_SPACING = 3'd3,
    REG_ROWS_LEVEL = 3'd4,
    REG_DIST_STEP  = 3'd5,
    REG_RATE       = 3'd6,
    REG_STATIONS   = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POS_RD,
    S_DIFF,
    S_SQ_X,
    S_SQ_Y,
    S_SQRT,
    S_LOAD_D,
    S_DIV,
    S_TAB1,
    S_TAB2,
    S_PROD1,
    S_PROD2,
    S_LOAD_T,
    S_DELAY,
    S_STACK,
    S_WIN,
    S_WIN_LAST,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/backprojection_stack_peak.sv -----
// Delay-and-sum back-projection of one grid point with windowed stack peaks.
// Depends on bsp_pkg for store sizes, command codes and the sequencer states.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_ready    command and load / grid fields
//  out      out        out_valid / out_ready  window_index, window_peak, last_window
//
// Load commands write their store when accepted. An evaluation makes, for each station in
// use, a read-modify-write pass over the stack memory, 32 square-root steps and two
// 53-step divisions, and then a peak scan over each window. The stack memory port, at
// one sample per cycle, dominates the evaluation time.
// Reset is synchronous; no store is cleared, since the first station pass overwrites
// the stack. A stalled output holds the peak scan until the result is taken.
`default_nettype none

module backprojection_stack_peak (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [23:0]                       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic [5:0]                        station,
  input  wire logic [11:0]                       sample_index,
  input  wire logic signed [15:0]                sample_value,
  input  wire logic signed [27:0]                station_x,
  input  wire logic signed [27:0]                station_y,
  input  wire logic [13:0]                       table_index,
  input  wire logic [31:0]                       travel_time,
  input  wire logic [7:0]                        grid_x_index,
  input  wire logic [7:0]                        grid_y_index,
  input  wire logic [5:0]                        grid_depth_index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bsp_pkg::WIDX_BITS-1:0]          window_index,
  output logic [21:0]                            window_peak,
  output logic                                   last_window
);
  import bsp_pkg::*;

  // Configuration registers.
  logic signed [23:0] gx_origin, gy_origin;
  logic [15:0] gx_spacing, gy_spacing, dist_step, rate;
  logic [7:0]  rows_level;
  logic [6:0]  stations_use;

  // Sequencer state and evaluation context.
  state_t state, state_next;
  logic signed [29:0] cxq, cyq;
  logic [ROW_BITS-1:0] row;
  logic [19:0] dstep;
  logic [6:0]  n_st;
  logic        empty;
  logic [ST_BITS-1:0] s;
  logic [SMP_BITS-1:0] k;
  logic [WIDX_BITS-1:0] w;
  logic [5:0]  cnt;
  logic        div_pass;

  // Per-station datapath registers.
  logic [29:0] ex, ey;
  logic [59:0] ex2;
  logic [63:0] sq_n;
  logic [34:0] sq_rem;
  logic [31:0] sq_root;
  logic [52:0] dv_n;
  logic [19:0] dv_r;
  logic [19:0] rem_r;
  logic [COL_BITS-1:0] col_r;
  logic [31:0] t1, t2;
  logic [51:0] p1, p2;
  logic        far;
  logic [SMP_BITS-1:0] off;

  // Memory read data and pipeline flags.
  logic signed [27:0] sx_q, sy_q;
  logic signed [15:0] trace_q;
  logic [31:0] tab_q;
  logic signed [ACC_W-1:0] acc_q;
  logic        st_v, st_tv, st_first, win_v;
  logic [SMP_BITS-1:0] st_k;
  logic [21:0] peak;

  // Memories.
  logic signed [27:0] sx_mem [MAX_STATIONS];
  logic signed [27:0] sy_mem [MAX_STATIONS];
  logic signed [15:0] trace_mem [MAX_STATIONS*TRACE_SAMPLES];
  logic [31:0] table_mem [TABLE_ROWS*TABLE_COLS];
  logic signed [ACC_W-1:0] acc_mem [TRACE_SAMPLES];

  // Combinational helpers.
  logic        in_acc, load_pos, load_smp, load_time, eval_go;
  logic signed [25:0] cx_sum, cy_sum;
  logic [13:0] row_prod;
  logic [15:0] step_nz;
  logic signed [30:0] dx, dy;
  logic [34:0] sq_sh, sq_trial;
  logic        sq_ge;
  logic [20:0] dv_sh;
  logic        dv_ge;
  logic [COL_BITS-1:0] col_c, col2;
  logic [47:0] t_prod;
  logic [48:0] t_round;
  logic [SMP_BITS:0] idx;
  logic [SMP_BITS-1:0] acc_raddr;
  logic [ST_BITS+SMP_BITS-1:0] trace_raddr;
  logic [ROW_BITS+COL_BITS-1:0] tab_raddr;
  logic signed [ACC_W-1:0] acc_wdata, acc_base, acc_add;
  logic [21:0] abs_v;
  logic        st_last, win_end, emit_go;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_pos  = in_acc && (cmd_t'(command) == CMD_POS);
  assign load_smp  = in_acc && (cmd_t'(command) == CMD_SAMPLE);
  assign load_time = in_acc && (cmd_t'(command) == CMD_TIME);
  assign eval_go   = in_acc && (cmd_t'(command) == CMD_EVAL);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gx_origin    <= '0;
      gy_origin    <= '0;
      gx_spacing   <= 16'd1;
      gy_spacing   <= 16'd1;
      rows_level   <= 8'd1;
      dist_step    <= 16'd1;
      rate         <= 16'd100;
      stations_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GX_ORIGIN:  gx_origin    <= cfg_data;
        REG_GY_ORIGIN:  gy_origin    <= cfg_data;
        REG_GX_SPACING: gx_spacing   <= cfg_data[15:0];
        REG_GY_SPACING: gy_spacing   <= cfg_data[15:0];
        REG_ROWS_LEVEL: rows_level   <= cfg_data[7:0];
        REG_DIST_STEP:  dist_step    <= cfg_data[15:0];
        REG_RATE:       rate         <= cfg_data[15:0];
        REG_STATIONS:   stations_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Grid point and table row, formed when an evaluation is accepted.
  assign cx_sum   = {{2{gx_origin[23]}}, gx_origin} + $signed({2'b0, 24'(grid_x_index * gx_spacing)});
  assign cy_sum   = {{2{gy_origin[23]}}, gy_origin} + $signed({2'b0, 24'(grid_y_index * gy_spacing)});
  assign row_prod = 14'(grid_depth_index * rows_level);
  assign step_nz  = (dist_step == '0) ? 16'd1 : dist_step;

  // Station offsets from the grid point.
  assign dx = 31'(sx_q) - 31'(cxq);
  assign dy = 31'(sy_q) - 31'(cyq);

  // One square-root digit per cycle.
  assign sq_sh    = {sq_rem[32:0], sq_n[63:62]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);

  // One restoring-division bit per cycle.
  assign dv_sh = {dv_r, dv_n[52]};
  assign dv_ge = (dv_sh >= {1'b0, dstep});

  // Table columns, clamped at the row end.
  assign col_c = (|dv_n[52:COL_BITS]) ? {COL_BITS{1'b1}} : dv_n[COL_BITS-1:0];
  assign col2  = (col_r == {COL_BITS{1'b1}}) ? col_r : col_r + 1'b1;

  // Travel time to sample delay, rounding half up.
  assign t_prod  = dv_n[31:0] * rate;
  assign t_round = 49'(t_prod) + 49'd32768;

  // Memory addresses.
  assign idx         = {1'b0, k} + {1'b0, off};
  assign acc_raddr   = k;
  assign trace_raddr = {s, idx[SMP_BITS-1:0]};
  assign tab_raddr   = (state == S_TAB2) ? {row, col2} : {row, col_c};

  // Stack update: the first station overwrites, later ones add.
  assign acc_base  = st_first ? '0 : acc_q;
  assign acc_add   = st_tv ? ACC_W'(trace_q) : '0;
  assign acc_wdata = acc_base + acc_add;

  assign abs_v = empty ? '0 : (acc_q[ACC_W-1] ? 22'(-acc_q) : acc_q[21:0]);

  assign st_last = ({1'b0, s} == n_st - 7'd1);
  assign win_end = (k[WIN_BITS-1:0] == {WIN_BITS{1'b1}});
  assign emit_go = !out_valid || out_ready;

  // Station position stores.
  always_ff @(posedge clk) begin
    if (load_pos) begin
      sx_mem[station] <= station_x;
      sy_mem[station] <= station_y;
    end
    sx_q <= sx_mem[s];
    sy_q <= sy_mem[s];
  end

  // Trace store.
  always_ff @(posedge clk) begin
    if (load_smp) begin
      trace_mem[{station, sample_index}] <= sample_value;
    end
    trace_q <= trace_mem[trace_raddr];
  end

  // Travel-time table.
  always_ff @(posedge clk) begin
    if (load_time) begin
      table_mem[table_index] <= travel_time;
    end
    tab_q <= table_mem[tab_raddr];
  end

  // Stack accumulator.
  always_ff @(posedge clk) begin
    if (st_v) begin
      acc_mem[st_k] <= acc_wdata;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (eval_go) begin
          state_next = (stations_use == '0) ? S_WIN : S_POS_RD;
        end
      end
      S_POS_RD: state_next = S_DIFF;
      S_DIFF:   state_next = S_SQ_X;
      S_SQ_X:   state_next = S_SQ_Y;
      S_SQ_Y:   state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == 6'(SQRT_STEPS - 1)) state_next = S_LOAD_D;
      end
      S_LOAD_D: state_next = S_DIV;
      S_DIV: begin
        if (cnt == 6'(DIV_STEPS - 1)) state_next = div_pass ? S_DELAY : S_TAB1;
      end
      S_TAB1:   state_next = S_TAB2;
      S_TAB2:   state_next = S_PROD1;
      S_PROD1:  state_next = S_PROD2;
      S_PROD2:  state_next = S_LOAD_T;
      S_LOAD_T: state_next = S_DIV;
      S_DELAY:  state_next = S_STACK;
      S_STACK: begin
        if (k == {SMP_BITS{1'b1}}) state_next = st_last ? S_WIN : S_POS_RD;
      end
      S_WIN: begin
        if (win_end) state_next = S_WIN_LAST;
      end
      S_WIN_LAST: state_next = S_EMIT;
      S_EMIT: begin
        if (emit_go) state_next = (w == WIDX_BITS'(NUM_WINDOWS - 1)) ? S_IDLE : S_WIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Pipeline flags and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v      <= 1'b0;
      win_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_v  <= (state == S_STACK);
      win_v <= (state == S_WIN);
      if (state == S_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    st_k     <= k;
    st_tv    <= !far && !idx[SMP_BITS];
    st_first <= (s == '0);
    if (win_v && abs_v > peak) begin
      peak <= abs_v;
    end
    case (state)
      S_IDLE: begin
        if (eval_go) begin
          cxq   <= {cx_sum, 4'b0};
          cyq   <= {cy_sum, 4'b0};
          row   <= (row_prod > 14'(TABLE_ROWS - 1)) ? ROW_BITS'(TABLE_ROWS - 1)
                                                    : row_prod[ROW_BITS-1:0];
          dstep <= {step_nz, 4'b0};
          n_st  <= (stations_use > 7'(MAX_STATIONS)) ? 7'(MAX_STATIONS) : stations_use;
          empty <= (stations_use == '0);
          s     <= '0;
          k     <= '0;
          w     <= '0;
          peak  <= '0;
        end
      end
      S_DIFF: begin
        ex <= dx[30] ? 30'(-dx) : dx[29:0];
        ey <= dy[30] ? 30'(-dy) : dy[29:0];
      end
      S_SQ_X: ex2 <= ex * ex;
      S_SQ_Y: begin
        sq_n    <= 64'(ex2) + 64'(ey * ey);
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
      end
      S_SQRT: begin
        sq_n    <= {sq_n[61:0], 2'b00};
        sq_rem  <= sq_ge ? sq_sh - sq_trial : sq_sh;
        sq_root <= {sq_root[30:0], sq_ge};
        cnt     <= cnt + 6'd1;
      end
      S_LOAD_D: begin
        dv_n     <= 53'(sq_root);
        dv_r     <= '0;
        cnt      <= '0;
        div_pass <= 1'b0;
      end
      S_DIV: begin
        dv_r <= dv_ge ? 20'(dv_sh - {1'b0, dstep}) : dv_sh[19:0];
        dv_n <= {dv_n[51:0], dv_ge};
        cnt  <= cnt + 6'd1;
      end
      S_TAB1: begin
        rem_r <= dv_r;
        col_r <= col_c;
      end
      S_TAB2:  t1 <= tab_q;
      S_PROD1: begin
        t2 <= tab_q;
        p1 <= t1 * (dstep - rem_r);
      end
      S_PROD2: p2 <= t2 * rem_r;
      S_LOAD_T: begin
        dv_n     <= 53'(p1) + 53'(p2);
        dv_r     <= '0;
        cnt      <= '0;
        div_pass <= 1'b1;
      end
      S_DELAY: begin
        far <= |t_round[48:16+SMP_BITS];
        off <= t_round[16+SMP_BITS-1:16];
      end
      S_STACK: begin
        k <= k + 1'b1;
        if (k == {SMP_BITS{1'b1}} && !st_last) begin
          s <= s + 1'b1;
        end
      end
      S_WIN: k <= k + 1'b1;
      S_EMIT: begin
        if (emit_go) begin
          window_index <= w;
          window_peak  <= peak;
          last_window  <= (w == WIDX_BITS'(NUM_WINDOWS - 1));
          peak         <= '0;
          w            <= w + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bsp_checker.sv -----
// Port-level checks for backprojection_stack_peak, attached by a bind statement.
// Depends on bsp_pkg for the command code and the window count.
`default_nettype none

module bsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  command,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  window_index,
  input wire logic [21:0] window_peak,
  input wire logic        last_window
);
  import bsp_pkg::*;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_index) && $stable(window_peak)
      && $stable(last_window))
    else $error("output changed while stalled");

  // An evaluation occupies the block, so no transaction follows at once.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_EVAL |=> !in_ready)
    else $error("input taken right after an evaluation");

  // The final window flag marks the last window number.
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_window |-> window_index == 5'(NUM_WINDOWS - 1))
    else $error("last window flag on wrong window");

  // Until the final window is delivered the block takes no new transaction.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_window |=> !in_ready)
    else $error("input taken during window output");

  // A stack of 64 traces cannot exceed 2^21 in magnitude.
  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_peak <= 22'd2097152)
    else $error("window peak out of range");

endmodule

bind backprojection_stack_peak bsp_checker u_bsp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .command      (command),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .window_index (window_index),
  .window_peak  (window_peak),
  .last_window  (last_window)
);

`default_nettype wire
